### design/i128_pkg.sv
// package: operation codes, widths and state type for the 128-bit alu
package i128_pkg;
  localparam int unsigned WordBitsDef = 128;
  localparam int unsigned HalfBits = 64;
  localparam int unsigned CmdBits = 4;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_AND = 4'd2,
    CMD_OR  = 4'd3,
    CMD_XOR = 4'd4,
    CMD_NOT = 4'd5,
    CMD_SHL = 4'd6,
    CMD_SAR = 4'd7,
    CMD_ROL = 4'd8,
    CMD_ROR = 4'd9,
    CMD_CMP = 4'd10,
    CMD_MUL = 4'd11,
    CMD_DIV = 4'd12
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SER,
    ST_FIX,
    ST_DONE
  } state_e;

  // passes of the serial engine
  typedef enum logic [1:0] {
    PH_PREP,
    PH_MAIN,
    PH_FIX
  } phase_e;
endpackage

### design/i128_serial.sv
// bit-serial engine: add/sub/compare/negate one bit a cycle, shift-add multiply,
// restoring divide with a bit-serial trial subtract
module i128_serial import i128_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [CmdBits-1:0]  cmd_i,
  input  logic [WordBits-1:0] a_i,
  input  logic [WordBits-1:0] b_i,
  output logic                done_o,
  output logic [WordBits-1:0] res_o,
  output logic                less_o,
  output logic                equal_o,
  output logic                greater_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);
  localparam logic [CntBits-1:0] Last = CntBits'(WordBits - 1);

  // serial passes: prepare/negate inputs, main, negate result
  state_e            state_q, state_d;
  logic [CntBits-1:0] bit_q, bit_d;   // bit within a serial pass
  logic [CntBits-1:0] it_q, it_d;     // iteration of mul/div outer loop
  phase_e            ph_q, ph_d;
  logic [WordBits-1:0] x_q, x_d;      // shift register a (dividend / multiplicand)
  logic [WordBits-1:0] y_q, y_d;      // shift register b
  logic [WordBits-1:0] r_q, r_d;      // accumulator / remainder / result
  logic [WordBits-1:0] t_q, t_d;      // trial difference
  logic [WordBits-1:0] q_q, q_d;      // quotient
  logic              c_q, c_d, c2_q, c2_d;
  logic              neq_q, neq_d, sgn_q, sgn_d;
  cmd_e              cmd;
  logic              sum, co, ab, bb;

  assign cmd = cmd_e'(cmd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      it_q    <= '0;
      ph_q    <= PH_PREP;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      it_q    <= it_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; r_q <= r_d; t_q <= t_d; q_q <= q_d;
    c_q <= c_d; c2_q <= c2_d; neq_q <= neq_d; sgn_q <= sgn_d;
  end

  always_comb begin
    state_d = state_q; bit_d = bit_q; it_d = it_q; ph_d = ph_q;
    x_d = x_q; y_d = y_q; r_d = r_q; t_d = t_q; q_d = q_q;
    c_d = c_q; c2_d = c2_q; neq_d = neq_q; sgn_d = sgn_q;
    done_o = 1'b0;
    ab = 1'b0; bb = 1'b0; sum = 1'b0; co = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          x_d = a_i; y_d = b_i; r_d = '0; t_d = '0; q_d = '0;
          bit_d = '0; it_d = '0; neq_d = 1'b0;
          sgn_d = a_i[WordBits-1] ^ b_i[WordBits-1];
          c_d = (cmd != CMD_ADD);  // +1 for sub / compare / negate
          c2_d = 1'b1;
          if (cmd == CMD_DIV) ph_d = PH_PREP;
          else ph_d = PH_MAIN;
          state_d = ST_SER;
        end
      end
      ST_SER: begin
        bit_d = bit_q + 1'b1;
        if (cmd == CMD_DIV && ph_q == PH_PREP) begin
          // negate both operands where negative, both in one pass
          ab = x_q[0] ^ a_i[WordBits-1];
          bb = y_q[0] ^ b_i[WordBits-1];
          {co, sum} = {1'b0, ab} + {1'b0, c_q & a_i[WordBits-1]};
          x_d = {sum, x_q[WordBits-1:1]};
          c_d = co;
          {co, sum} = {1'b0, bb} + {1'b0, c2_q & b_i[WordBits-1]};
          y_d = {sum, y_q[WordBits-1:1]};
          c2_d = co;
          if (bit_q == Last) begin
            bit_d = '0; ph_d = PH_MAIN; c_d = 1'b1;
            // clear the remainder before the first step
            r_d = '0;
          end
        end else if (cmd == CMD_DIV && ph_q == PH_MAIN) begin
          // per iteration: bit 0 loads next dividend bit; then serial rem - y
          if (bit_q == '0) begin
            r_d = {r_q[WordBits-2:0], x_q[WordBits-1]};
            x_d = {x_q[WordBits-2:0], 1'b0};
            c_d = 1'b1; c2_d = r_q[WordBits-1]; // shifted-out bit forces fit
            bit_d = CntBits'(1);
            t_d = '0;
          end else begin
            ab = r_q[0];
            bb = ~y_q[0];
            {co, sum} = {1'b0, ab} + {1'b0, bb} + {1'b0, c_q};
            t_d = {sum, t_q[WordBits-1:1]};
            r_d = {r_q[0], r_q[WordBits-1:1]};
            y_d = {y_q[0], y_q[WordBits-1:1]};
            c_d = co;
            if (bit_q == CntBits'(WordBits)) begin
              // carry out means rem >= y
              if (co | c2_q) begin
                r_d = {sum, t_q[WordBits-1:1]};
                q_d = {q_q[WordBits-2:0], 1'b1};
              end else begin
                q_d = {q_q[WordBits-2:0], 1'b0};
              end
              it_d = it_q + 1'b1;
              bit_d = '0;
              if (it_q == Last) begin
                if (sgn_q) begin
                  ph_d = PH_FIX; c_d = 1'b1; r_d = '0;
                end else begin
                  r_d = q_d; state_d = ST_DONE;
                end
              end
            end
          end
        end else if (ph_q == PH_FIX) begin
          // negate quotient serially
          {co, sum} = {1'b0, ~q_q[0]} + {1'b0, c_q};
          q_d = {1'b0, q_q[WordBits-1:1]};
          r_d = {sum, r_q[WordBits-1:1]};
          c_d = co;
          if (bit_q == Last) state_d = ST_DONE;
        end else if (cmd == CMD_MUL) begin
          // outer: per multiplier bit add x to r serially, then shift x
          if (bit_q == '0) begin
            c_d = 1'b0; t_d = '0;
          end
          ab = r_q[0];
          bb = x_q[0] & y_q[0];
          {co, sum} = {1'b0, ab} + {1'b0, bb} + {1'b0, c_d};
          r_d = {sum, r_q[WordBits-1:1]};
          x_d = {x_q[0], x_q[WordBits-1:1]};
          c_d = co;
          if (bit_q == Last) begin
            bit_d = '0;
            // x is rotated left by one here: clear bit 0 to get the shift
            x_d = {x_q[WordBits-1:1], 1'b0};
            y_d = {y_q[0], y_q[WordBits-1:1]};
            it_d = it_q + 1'b1;
            if (it_q == Last) state_d = ST_DONE;
          end else begin
            y_d = y_q;
          end
        end else begin
          // add / sub / compare
          ab = x_q[0];
          bb = (cmd == CMD_ADD) ? y_q[0] : ~y_q[0];
          {co, sum} = {1'b0, ab} + {1'b0, bb} + {1'b0, c_q};
          r_d = {sum, r_q[WordBits-1:1]};
          x_d = {1'b0, x_q[WordBits-1:1]};
          y_d = {1'b0, y_q[WordBits-1:1]};
          c_d = co;
          neq_d = neq_q | (x_q[0] ^ y_q[0]);
          if (bit_q == Last) begin
            // signed less from sign bits and unsigned borrow
            sgn_d = (x_q[0] ^ y_q[0]) ? x_q[0] : ~co;
            state_d = ST_DONE;
          end
        end
      end
      ST_FIX: state_d = ST_DONE;
      ST_DONE: begin
        done_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = r_q;
  assign less_o = neq_q & sgn_q;
  assign equal_o = ~neq_q;
  assign greater_o = neq_q & ~sgn_q;
endmodule

### design/int128_alu_mul_div.sv
// top level: signed 128-bit alu with bit-serial arithmetic
// usage:
//   assert start with cmd_i and operands while busy is low; the word is
//   taken at that edge and busy rises. the result word appears on res_hi_o,
//   res_lo_o and the flags for exactly one cycle with done_o high; the
//   receiver cannot stall, it must take the word in that cycle.
// how each command runs, once accepted:
//   logic ops, shifts, rotates: registered, one-step path
//   add, sub, cmp: one bit a cycle through a serial adder
//   mul: a serial add pass per multiplier bit
//   div: a negate pass, then a serial trial subtract per quotient bit, then
//   a serial negate pass when the quotient is negated
// one word at a time: next start accepted the cycle after done_o
// reset: asynchronous, active low; returns to idle, no result pending
// divide by zero takes the one-step path, with zero result and div_zero_o set
module int128_alu_mul_div import i128_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CmdBits-1:0]  cmd_i,
  input  logic [HalfBits-1:0] a_hi_i,
  input  logic [HalfBits-1:0] a_lo_i,
  input  logic [HalfBits-1:0] b_hi_i,
  input  logic [HalfBits-1:0] b_lo_i,
  output logic                done_o,
  output logic [HalfBits-1:0] res_hi_o,
  output logic [HalfBits-1:0] res_lo_o,
  output logic                less_o,
  output logic                equal_o,
  output logic                greater_o,
  output logic                div_zero_o
);
  logic [WordBits-1:0] a_w, b_w, ser_res, fast_res;
  logic [2*HalfBits-1:0] a_full, b_full, res_full;
  logic [CmdBits-1:0] cmd_q;
  logic [WordBits-1:0] a_q, b_q, fast_q;
  logic busy_q, fast_q_v, slow_q;
  logic ser_go, ser_done, ser_lt, ser_eq, ser_gt, dz_q;
  cmd_e cmd;
  logic accept;

  assign a_full = {a_hi_i, a_lo_i};
  assign b_full = {b_hi_i, b_lo_i};
  assign a_w = a_full[WordBits-1:0];
  assign b_w = b_full[WordBits-1:0];
  assign cmd = cmd_e'(cmd_i);
  assign accept = start & ~busy_q;
  assign busy = busy_q;

  // one-step operations
  always_comb begin
    case (cmd)
      CMD_AND: fast_res = a_w & b_w;
      CMD_OR:  fast_res = a_w | b_w;
      CMD_XOR: fast_res = a_w ^ b_w;
      CMD_NOT: fast_res = ~a_w;
      CMD_SHL: fast_res = {a_w[WordBits-2:0], 1'b0};
      CMD_SAR: fast_res = {a_w[WordBits-1], a_w[WordBits-1:1]};
      CMD_ROL: fast_res = {a_w[WordBits-2:0], a_w[WordBits-1]};
      CMD_ROR: fast_res = {a_w[0], a_w[WordBits-1:1]};
      default: fast_res = '0;
    endcase
  end

  // busy and path select: serial path for add, sub, cmp, mul, nonzero div
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fast_q_v <= 1'b0;
      slow_q <= 1'b0;
    end else begin
      fast_q_v <= 1'b0;
      if (accept) begin
        busy_q <= 1'b1;
        slow_q <= (cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_CMP ||
                   cmd == CMD_MUL || (cmd == CMD_DIV && b_w != '0));
        fast_q_v <= ~(cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_CMP ||
                      cmd == CMD_MUL || (cmd == CMD_DIV && b_w != '0));
      end else if (done_o) begin
        busy_q <= 1'b0;
        slow_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      a_q <= a_w;
      b_q <= b_w;
      fast_q <= fast_res;
      dz_q <= (cmd == CMD_DIV) && (b_w == '0);
    end
  end

  assign ser_go = slow_q & busy_q & ~ser_done & ~fast_q_v;

  i128_serial #(.WordBits(WordBits)) u_ser (
    .clk_i, .rst_ni,
    .go_i(ser_go), .cmd_i(cmd_q), .a_i(a_q), .b_i(b_q),
    .done_o(ser_done), .res_o(ser_res),
    .less_o(ser_lt), .equal_o(ser_eq), .greater_o(ser_gt)
  );

  assign done_o = fast_q_v | (slow_q & ser_done);
  always_comb begin
    res_full = '0;
    if (fast_q_v) res_full[WordBits-1:0] = fast_q;
    else if (cmd_e'(cmd_q) != CMD_CMP) res_full[WordBits-1:0] = ser_res;
  end
  assign res_hi_o = done_o ? res_full[2*HalfBits-1:HalfBits] : '0;
  assign res_lo_o = done_o ? res_full[HalfBits-1:0] : '0;
  // flags only while the word is shown
  assign less_o = done_o & ~fast_q_v & (cmd_e'(cmd_q) == CMD_CMP) & ser_lt;
  assign equal_o = done_o & ~fast_q_v & (cmd_e'(cmd_q) == CMD_CMP) & ser_eq;
  assign greater_o = done_o & ~fast_q_v & (cmd_e'(cmd_q) == CMD_CMP) & ser_gt;
  assign div_zero_o = fast_q_v & dz_q;
endmodule

### design/i128_checker.sv
// port-level checker for the 128-bit alu
module i128_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic less_o,
  input logic equal_o,
  input logic greater_o
);
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("word without pending item");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({less_o, equal_o, greater_o})) else $error("compare flags clash");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item taken without busy");
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy held after word");
endmodule

bind int128_alu_mul_div i128_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .less_o, .equal_o, .greater_o
);

### test/alu_scoreboard.sv
// checker: watches the alu command and result channels, predicts and compares
module alu_scoreboard import i128_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [CmdBits-1:0]  cmd_i,
  input  logic [HalfBits-1:0] a_hi_i,
  input  logic [HalfBits-1:0] a_lo_i,
  input  logic [HalfBits-1:0] b_hi_i,
  input  logic [HalfBits-1:0] b_lo_i,
  input  logic                done_i,
  input  logic [HalfBits-1:0] res_hi_i,
  input  logic [HalfBits-1:0] res_lo_i,
  input  logic                less_i,
  input  logic                equal_i,
  input  logic                greater_i,
  input  logic                div_zero_i,
  output int unsigned         err_count_o,
  output int unsigned         pending_o,
  output int unsigned         words_checked_o
);

  typedef struct packed {
    logic [127:0] res;
    logic         less;
    logic         equal;
    logic         greater;
    logic         div_zero;
  } alu_word_t;

  alu_word_t expected_words[$];

  int unsigned err_count = 0;
  int unsigned pending = 0;
  int unsigned words_checked = 0;

  assign err_count_o = err_count;
  assign pending_o = pending;
  assign words_checked_o = words_checked;

  function automatic alu_word_t alu_compute(logic [CmdBits-1:0] cmd,
                                            logic [127:0] a, logic [127:0] b);
    alu_word_t r;
    logic [127:0] mag_a;
    logic [127:0] mag_b;
    logic [127:0] quot;
    r = '0;
    case (cmd)
      CMD_ADD: r.res = a + b;
      CMD_SUB: r.res = a - b;
      CMD_AND: r.res = a & b;
      CMD_OR:  r.res = a | b;
      CMD_XOR: r.res = a ^ b;
      CMD_NOT: r.res = ~a;
      CMD_SHL: r.res = {a[126:0], 1'b0};
      CMD_SAR: r.res = {a[127], a[127:1]};
      CMD_ROL: r.res = {a[126:0], a[127]};
      CMD_ROR: r.res = {a[0], a[127:1]};
      CMD_CMP: begin
        r.less    = $signed(a) < $signed(b);
        r.equal   = a == b;
        r.greater = $signed(a) > $signed(b);
      end
      CMD_MUL: r.res = a * b;
      CMD_DIV: begin
        if (b == '0) begin
          r.div_zero = 1'b1;
        end else begin
          // divide magnitudes, then apply the sign; min / -1 wraps to min
          mag_a = a[127] ? -a : a;
          mag_b = b[127] ? -b : b;
          quot  = mag_a / mag_b;
          r.res = (a[127] ^ b[127]) ? -quot : quot;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  alu_word_t got;
  alu_word_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_i)
        expected_words = {expected_words,
                          alu_compute(cmd_i, {a_hi_i, a_lo_i}, {b_hi_i, b_lo_i})};
      if (done_i) begin
        got = {res_hi_i, res_lo_i, less_i, equal_i, greater_i, div_zero_i};
        if (expected_words.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("error: result word with nothing expected: %h", got);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (got !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("error: res exp %h got %h | lt/eq/gt/dz exp %b%b%b%b got %b%b%b%b",
                       want.res, got.res, want.less, want.equal, want.greater,
                       want.div_zero, got.less, got.equal, got.greater, got.div_zero);
          end
        end
      end
      pending = expected_words.size();
    end
  end

endmodule

### test/testbench.sv
// top of the alu testbench: clock, reset, command stimulus and verdict
module testbench;
  import i128_pkg::*;

  localparam int unsigned CycleLimit = 40_000_000;
  localparam logic [127:0] MinVal = {1'b1, 127'b0};
  localparam logic [127:0] MaxVal = {1'b0, {127{1'b1}}};
  localparam logic [127:0] AllOnes = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CmdBits-1:0]  cmd_i = '0;
  logic [HalfBits-1:0] a_hi_i = '0;
  logic [HalfBits-1:0] a_lo_i = '0;
  logic [HalfBits-1:0] b_hi_i = '0;
  logic [HalfBits-1:0] b_lo_i = '0;
  logic                done_o;
  logic [HalfBits-1:0] res_hi_o;
  logic [HalfBits-1:0] res_lo_o;
  logic                less_o;
  logic                equal_o;
  logic                greater_o;
  logic                div_zero_o;
  int unsigned         err_count;
  int unsigned         pending;
  int unsigned         words_checked;
  int unsigned         cycles = 0;
  int unsigned         sender_idle_pct = 0;
  int unsigned         n_muldiv = 0;

  always #5 clk_i = ~clk_i;

  int128_alu_mul_div DUT (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .a_hi_i, .a_lo_i, .b_hi_i, .b_lo_i,
    .done_o, .res_hi_o, .res_lo_o, .less_o, .equal_o, .greater_o, .div_zero_o
  );

  alu_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cmd_i, .a_hi_i, .a_lo_i,
    .b_hi_i, .b_lo_i, .done_i(done_o), .res_hi_i(res_hi_o), .res_lo_i(res_lo_o),
    .less_i(less_o), .equal_i(equal_o), .greater_i(greater_o),
    .div_zero_i(div_zero_o), .err_count_o(err_count), .pending_o(pending),
    .words_checked_o(words_checked)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one word and hold it until the alu takes it
  task automatic issue_word(logic [CmdBits-1:0] cmd, logic [127:0] a, logic [127:0] b);
    start  <= 1'b1;
    cmd_i  <= cmd;
    a_hi_i <= a[127:64];
    a_lo_i <= a[63:0];
    b_hi_i <= b[127:64];
    b_lo_i <= b[63:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // sender gap, start dropped only when a gap is taken
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
  endtask

  function automatic logic [127:0] rand_wide();
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    // sometimes a small value, sometimes sign extended
    case ($urandom_range(5))
      0: v = 128'($urandom_range(20));
      1: v = -128'($urandom_range(20));
      2: v = {{96{v[31]}}, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  // random word: mul and div kept rare, they run the longest serial passes
  task automatic random_word();
    logic [CmdBits-1:0] cmd;
    logic [127:0] b;
    int unsigned pick;
    pick = $urandom_range(99);
    b = rand_wide();
    if (pick < 2) begin
      cmd = CMD_MUL;
      n_muldiv++;
    end else if (pick < 5) begin
      cmd = CMD_DIV;
      if ($urandom_range(3) == 0) b = '0;
      else n_muldiv++;
    end else begin
      cmd = 4'($urandom_range(15));
      if (cmd == CMD_MUL || cmd == CMD_DIV) cmd = CMD_CMP;
      // equal operands now and then for compare
      if (cmd == CMD_CMP && $urandom_range(3) == 0) begin
        issue_word(cmd, b, b);
        return;
      end
    end
    issue_word(cmd, rand_wide(), b);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    issue_word(CMD_ADD, MaxVal, 128'd1);
    issue_word(CMD_ADD, AllOnes, AllOnes);
    issue_word(CMD_SUB, MinVal, 128'd1);
    issue_word(CMD_SUB, '0, AllOnes);
    issue_word(CMD_AND, AllOnes, {64'h0, 64'hffff_ffff_ffff_ffff});
    issue_word(CMD_OR, MinVal, 128'd1);
    issue_word(CMD_XOR, AllOnes, MaxVal);
    issue_word(CMD_NOT, '0, AllOnes);
    issue_word(CMD_SHL, MinVal | 128'd1, '0);
    issue_word(CMD_SAR, MinVal | 128'd1, '0);
    issue_word(CMD_ROL, MinVal | 128'd2, '0);
    issue_word(CMD_ROR, 128'd1, '0);
    issue_word(CMD_CMP, MinVal, MaxVal);
    issue_word(CMD_CMP, MaxVal, MinVal);
    issue_word(CMD_CMP, AllOnes, AllOnes);
    issue_word(CMD_MUL, MaxVal, MaxVal);
    issue_word(CMD_MUL, AllOnes, AllOnes);
    issue_word(CMD_DIV, MaxVal, '0);
    issue_word(CMD_DIV, MinVal, AllOnes);
    issue_word(CMD_DIV, -128'd7, 128'd2);
    issue_word(CMD_DIV, 128'd3, -128'd5);
    issue_word(4'd13, AllOnes, AllOnes);
    issue_word(4'd14, AllOnes, AllOnes);
    issue_word(4'd15, AllOnes, AllOnes);
    n_muldiv = 5;

    // random phases: light sender idling, heavy idling, then back to back
    sender_idle_pct = 9;
    repeat (540) random_word();
    // drain fully before carrying on
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || done_o) @(posedge clk_i);
    sender_idle_pct = 82;
    repeat (540) random_word();
    sender_idle_pct = 0;
    repeat (545) random_word();
    start <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("checked %0d result words over all 16 command codes, %0d of them mul or nonzero div",
             words_checked, n_muldiv);
    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d words never answered", err_count, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
design/i128_pkg.sv
design/i128_serial.sv
design/int128_alu_mul_div.sv
design/i128_checker.sv
test/alu_scoreboard.sv
test/testbench.sv
